### hdl/biquad_iir_section_unit_defines.svh
// ---------------------------------------------------------------------------
// biquad_iir_section_unit_defines
// assertion macros shared by the biquad section rtl
// ---------------------------------------------------------------------------
`ifndef BIQUAD_IIR_SECTION_UNIT_DEFINES_SVH
`define BIQUAD_IIR_SECTION_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BIQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad assertion failed");

// next-cycle implication
`define BIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad assertion failed");

`else

`define BIQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define BIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/biq_pkg.sv
// ---------------------------------------------------------------------------
// biq_pkg
// types, register codes and microcode format of the biquad section
// ---------------------------------------------------------------------------
package biq_pkg;

    localparam int COEF_BITS    = 18;
    localparam int CFG_IDX_BITS = 3;
    localparam int UPC_BITS     = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B1        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B2        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRUCTURE_MODE = 3'd5;

    // reset values
    localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 18'sd16384;
    localparam logic signed [COEF_BITS-1:0] COEF_ZERO     = '0;

    // structure mode codes
    localparam logic MODE_DF2 = 1'b0;
    localparam logic MODE_DF1 = 1'b1;

    // microcode entry points
    localparam logic [UPC_BITS-1:0] DISPATCH_ADDR = 4'd0;
    localparam logic [UPC_BITS-1:0] DF1_ENTRY     = 4'd8;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_LOAD_P,
        ACC_ADD_P,
        ACC_SUB_P
    } t_acc_op;

    typedef enum logic [2:0] {
        CS_B0,
        CS_B1,
        CS_B2,
        CS_A1,
        CS_A2
    } t_coef_sel;

    typedef enum logic [2:0] {
        DS_X,
        DS_W,
        DS_D1,
        DS_D2,
        DS_X1,
        DS_X2
    } t_data_sel;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_DF2,
        WB_DF1
    } t_wb_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_BR_DF1,
        SEQ_END
    } t_seq_op;

    // one control word; acc_op acts on the product formed by the previous word
    typedef struct packed {
        t_acc_op              acc_op;
        t_coef_sel            coef_sel;
        t_data_sel            data_sel;
        logic                 save_w;
        t_wb_op               wb_op;
        t_seq_op              seq_op;
        logic [UPC_BITS-1:0]  target;
    } t_ucode;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coefs;

endpackage

### hdl/biq_if.sv
// ---------------------------------------------------------------------------
// biq_if
// valid/ready channels of the biquad section: samples in, samples out, config
// ---------------------------------------------------------------------------
interface biq_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface biq_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [biq_pkg::CFG_IDX_BITS-1:0]     index;
    logic [biq_pkg::COEF_BITS-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/biquad_iir_section_unit.sv
// ---------------------------------------------------------------------------
// biquad_iir_section_unit: second-order iir section, direct form i or ii
// flow: each item runs an 8-word microcode program that passes five products
//   through one shared multiplier; the next item is accepted only as the last
//   one retires, and the last word stalls while the output register is full
// reset: synchronous active low; coefficients return to pass-through, delays
//   are loaded from the first sample after reset or a listed config write
// ---------------------------------------------------------------------------
`include "biquad_iir_section_unit_defines.svh"

module biquad_iir_section_unit #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14,
    parameter int STATE_BITS     = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    biq_in_if.sink      i_smp,
    biq_out_if.source   o_smp,
    biq_cfg_if.sink     i_cfg
);

    // sequencer state
    logic                          r_busy;
    logic [biq_pkg::UPC_BITS-1:0]  r_pc;
    logic [biq_pkg::UPC_BITS-1:0]  n_pc;
    logic                          r_primed;

    // configuration
    biq_pkg::t_coefs               r_coefs;
    logic                          r_mode;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    biq_pkg::t_ucode               ctl;
    logic                          in_acc;
    logic                          cfg_acc;
    logic                          cfg_listed;
    logic                          out_acc;
    logic                          at_end;
    logic                          finish_go;
    logic                          step;
    logic signed [SAMPLE_BITS-1:0] dp_sample;

    // control store lookup on the current step
    biq_ucode_rom u_rom (
        .i_addr (r_pc),
        .o_word (ctl)
    );

    biq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_BITS     (STATE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_step       (step),
        .i_load       (in_acc),
        .i_prime      (in_acc && !r_primed),
        .i_sample     (i_smp.sample_in),
        .i_coefs      (r_coefs),
        .i_ctl        (ctl),
        .o_sample_out (dp_sample)
    );

    // the last word waits while the previous result has not been taken
    assign at_end    = (ctl.seq_op == biq_pkg::SEQ_END);
    assign out_acc   = r_out_valid && o_smp.ready;
    assign finish_go = r_busy && at_end && (!r_out_valid || o_smp.ready);
    assign step      = r_busy && (!at_end || finish_go);

    // a new item enters in the cycle the current one retires
    assign i_smp.ready = !r_busy || finish_go;
    assign in_acc      = i_smp.valid && i_smp.ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;
    assign cfg_listed  = (i_cfg.index <= biq_pkg::REG_STRUCTURE_MODE);

    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out_sample;

    // next step: sequential, mode branch, hold at the last word, or restart on a new item
    always_comb begin
        n_pc = r_pc;
        if (in_acc) begin
            n_pc = biq_pkg::DISPATCH_ADDR;
        end else if (step) begin
            unique case (ctl.seq_op)
                biq_pkg::SEQ_NEXT:   n_pc = r_pc + biq_pkg::UPC_BITS'(1);
                biq_pkg::SEQ_BR_DF1: n_pc = (r_mode == biq_pkg::MODE_DF1)
                                            ? ctl.target
                                            : r_pc + biq_pkg::UPC_BITS'(1);
                biq_pkg::SEQ_END:    n_pc = r_pc;
                default:             n_pc = r_pc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= biq_pkg::DISPATCH_ADDR;
        end else begin
            r_pc <= n_pc;
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (finish_go) begin
                r_busy <= 1'b0;
            end
        end
    end

    // priming flag: a listed config write wins over an accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (cfg_acc && cfg_listed) begin
            r_primed <= 1'b0;
        end else if (in_acc) begin
            r_primed <= 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= biq_pkg::COEF_B0_RESET;
            r_coefs.b1 <= biq_pkg::COEF_ZERO;
            r_coefs.b2 <= biq_pkg::COEF_ZERO;
            r_coefs.a1 <= biq_pkg::COEF_ZERO;
            r_coefs.a2 <= biq_pkg::COEF_ZERO;
            r_mode     <= biq_pkg::MODE_DF2;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                biq_pkg::REG_COEF_B0:        r_coefs.b0 <= i_cfg.data;
                biq_pkg::REG_COEF_B1:        r_coefs.b1 <= i_cfg.data;
                biq_pkg::REG_COEF_B2:        r_coefs.b2 <= i_cfg.data;
                biq_pkg::REG_COEF_A1:        r_coefs.a1 <= i_cfg.data;
                biq_pkg::REG_COEF_A2:        r_coefs.a2 <= i_cfg.data;
                biq_pkg::REG_STRUCTURE_MODE: r_mode     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // output register; the downstream ready still gates the sequencer's last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish_go) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish_go) begin
            r_out_sample <= dp_sample;
        end
    end

    // an accepted item always starts at the dispatch word
    `BIQ_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_busy && (r_pc == biq_pkg::DISPATCH_ADDR))
    // direct form i branches to its own program
    `BIQ_ASSERT_NEXT(a_df1_branch, i_clk, i_rst_n, r_busy && (r_pc == biq_pkg::DISPATCH_ADDR) && (r_mode == biq_pkg::MODE_DF1), r_pc == biq_pkg::DF1_ENTRY)
    // a blocked last step holds its place
    `BIQ_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_busy && at_end && !finish_go, $stable(r_pc) && r_busy)
    // a listed config write forces reloading of the delays
    `BIQ_ASSERT_NEXT(a_cfg_unprimes, i_clk, i_rst_n, cfg_acc && cfg_listed, !r_primed)

endmodule

### hdl/biq_ucode_rom.sv
// ---------------------------------------------------------------------------
// biq_ucode_rom
// control store: one word per step of the df2 and df1 programs
// ---------------------------------------------------------------------------
module biq_ucode_rom (
    input  logic [biq_pkg::UPC_BITS-1:0] i_addr,
    output biq_pkg::t_ucode              o_word
);

    function automatic biq_pkg::t_ucode uw(
        biq_pkg::t_acc_op              acc_op,
        biq_pkg::t_coef_sel            coef_sel,
        biq_pkg::t_data_sel            data_sel,
        logic                          save_w,
        biq_pkg::t_wb_op               wb_op,
        biq_pkg::t_seq_op              seq_op,
        logic [biq_pkg::UPC_BITS-1:0]  target
    );
        biq_pkg::t_ucode w;
        w.acc_op   = acc_op;
        w.coef_sel = coef_sel;
        w.data_sel = data_sel;
        w.save_w   = save_w;
        w.wb_op    = wb_op;
        w.seq_op   = seq_op;
        w.target   = target;
        return w;
    endfunction

    always_comb begin
        unique case (i_addr)
            // dispatch on structure mode
            4'd0: o_word = uw(biq_pkg::ACC_HOLD, biq_pkg::CS_B0, biq_pkg::DS_X, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_BR_DF1, biq_pkg::DF1_ENTRY);
            // direct form II: w = (x<<f - a1*w1 - a2*w2) >> f
            4'd1: o_word = uw(biq_pkg::ACC_LOAD_X, biq_pkg::CS_A1, biq_pkg::DS_D1, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd2: o_word = uw(biq_pkg::ACC_SUB_P, biq_pkg::CS_A2, biq_pkg::DS_D2, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd3: o_word = uw(biq_pkg::ACC_SUB_P, biq_pkg::CS_B1, biq_pkg::DS_D1, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            // capture w, restart sum with b1*w1
            4'd4: o_word = uw(biq_pkg::ACC_LOAD_P, biq_pkg::CS_B2, biq_pkg::DS_D2, 1'b1,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd5: o_word = uw(biq_pkg::ACC_ADD_P, biq_pkg::CS_B0, biq_pkg::DS_W, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd6: o_word = uw(biq_pkg::ACC_ADD_P, biq_pkg::CS_B0, biq_pkg::DS_X, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd7: o_word = uw(biq_pkg::ACC_HOLD, biq_pkg::CS_B0, biq_pkg::DS_X, 1'b0,
                              biq_pkg::WB_DF2, biq_pkg::SEQ_END, '0);
            // direct form I: b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
            4'd8: o_word = uw(biq_pkg::ACC_HOLD, biq_pkg::CS_B0, biq_pkg::DS_X, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd9: o_word = uw(biq_pkg::ACC_LOAD_P, biq_pkg::CS_B1, biq_pkg::DS_X1, 1'b0,
                              biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd10: o_word = uw(biq_pkg::ACC_ADD_P, biq_pkg::CS_B2, biq_pkg::DS_X2, 1'b0,
                               biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd11: o_word = uw(biq_pkg::ACC_ADD_P, biq_pkg::CS_A1, biq_pkg::DS_D1, 1'b0,
                               biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd12: o_word = uw(biq_pkg::ACC_SUB_P, biq_pkg::CS_A2, biq_pkg::DS_D2, 1'b0,
                               biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd13: o_word = uw(biq_pkg::ACC_SUB_P, biq_pkg::CS_B0, biq_pkg::DS_X, 1'b0,
                               biq_pkg::WB_NONE, biq_pkg::SEQ_NEXT, '0);
            4'd14: o_word = uw(biq_pkg::ACC_HOLD, biq_pkg::CS_B0, biq_pkg::DS_X, 1'b0,
                               biq_pkg::WB_DF1, biq_pkg::SEQ_END, '0);
            default: o_word = uw(biq_pkg::ACC_HOLD, biq_pkg::CS_B0, biq_pkg::DS_X, 1'b0,
                                 biq_pkg::WB_NONE, biq_pkg::SEQ_END, '0);
        endcase
    end

endmodule

### hdl/biq_datapath.sv
// ---------------------------------------------------------------------------
// biq_datapath
// shared multiplier, accumulator, scaling/saturation and delay registers
// ---------------------------------------------------------------------------
module biq_datapath #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14,
    parameter int STATE_BITS     = 24
) (
    input  logic                          i_clk,
    input  logic                          i_step,
    input  logic                          i_load,
    input  logic                          i_prime,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  biq_pkg::t_coefs               i_coefs,
    input  biq_pkg::t_ucode               i_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int OPW   = (SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS;
    localparam int PRODW = biq_pkg::COEF_BITS + OPW;
    localparam int XSHW  = SAMPLE_BITS + COEF_FRAC_BITS;
    localparam int BASEW = (PRODW > XSHW) ? PRODW : XSHW;
    localparam int ACCW  = BASEW + 3;

    logic signed [SAMPLE_BITS-1:0]        r_x;
    logic signed [STATE_BITS-1:0]         r_w;
    logic signed [STATE_BITS-1:0]         r_d1;
    logic signed [STATE_BITS-1:0]         r_d2;
    logic signed [SAMPLE_BITS-1:0]        r_x1;
    logic signed [SAMPLE_BITS-1:0]        r_x2;
    logic signed [PRODW-1:0]              r_prod;
    logic signed [ACCW-1:0]               r_acc;

    logic signed [biq_pkg::COEF_BITS-1:0] coef_op;
    logic signed [OPW-1:0]                data_op;
    logic signed [PRODW-1:0]              mul_res;
    logic signed [ACCW-1:0]               n_acc;
    logic signed [ACCW-1:0]               acc_sh;
    logic signed [ACCW-1:0]               prod_ext;
    logic                                 fits_state;
    logic                                 fits_out;
    logic signed [STATE_BITS-1:0]         w_sat;
    logic signed [OPW-1:0]                x_ext;
    logic                                 x_fits_state;
    logic signed [STATE_BITS-1:0]         x_sat;

    // operand selection
    always_comb begin
        unique case (i_ctl.coef_sel)
            biq_pkg::CS_B0: coef_op = i_coefs.b0;
            biq_pkg::CS_B1: coef_op = i_coefs.b1;
            biq_pkg::CS_B2: coef_op = i_coefs.b2;
            biq_pkg::CS_A1: coef_op = i_coefs.a1;
            biq_pkg::CS_A2: coef_op = i_coefs.a2;
            default:        coef_op = i_coefs.b0;
        endcase
    end

    always_comb begin
        unique case (i_ctl.data_sel)
            biq_pkg::DS_X:  data_op = OPW'(r_x);
            biq_pkg::DS_W:  data_op = OPW'(r_w);
            biq_pkg::DS_D1: data_op = OPW'(r_d1);
            biq_pkg::DS_D2: data_op = OPW'(r_d2);
            biq_pkg::DS_X1: data_op = OPW'(r_x1);
            biq_pkg::DS_X2: data_op = OPW'(r_x2);
            default:        data_op = OPW'(r_x);
        endcase
    end

    assign mul_res  = PRODW'(coef_op) * PRODW'(data_op);
    assign prod_ext = ACCW'(r_prod);

    always_comb begin
        unique case (i_ctl.acc_op)
            biq_pkg::ACC_HOLD:   n_acc = r_acc;
            biq_pkg::ACC_LOAD_X: n_acc = ACCW'(r_x) <<< COEF_FRAC_BITS;
            biq_pkg::ACC_LOAD_P: n_acc = prod_ext;
            biq_pkg::ACC_ADD_P:  n_acc = r_acc + prod_ext;
            biq_pkg::ACC_SUB_P:  n_acc = r_acc - prod_ext;
            default:             n_acc = r_acc;
        endcase
    end

    // scale by 2^-f (floor) and saturate
    assign acc_sh     = r_acc >>> COEF_FRAC_BITS;
    assign fits_state = (&acc_sh[ACCW-1:STATE_BITS-1]) | ~(|acc_sh[ACCW-1:STATE_BITS-1]);
    assign fits_out   = (&acc_sh[ACCW-1:SAMPLE_BITS-1]) | ~(|acc_sh[ACCW-1:SAMPLE_BITS-1]);
    assign w_sat      = fits_state ? acc_sh[STATE_BITS-1:0]
                                   : {acc_sh[ACCW-1], {(STATE_BITS-1){~acc_sh[ACCW-1]}}};
    assign o_sample_out = fits_out ? acc_sh[SAMPLE_BITS-1:0]
                                   : {acc_sh[ACCW-1], {(SAMPLE_BITS-1){~acc_sh[ACCW-1]}}};

    // incoming sample clipped to state width for priming
    assign x_ext        = OPW'(i_sample);
    assign x_fits_state = (&x_ext[OPW-1:STATE_BITS-1]) | ~(|x_ext[OPW-1:STATE_BITS-1]);
    assign x_sat        = x_fits_state ? x_ext[STATE_BITS-1:0]
                                       : {x_ext[OPW-1], {(STATE_BITS-1){~x_ext[OPW-1]}}};

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_prod <= mul_res;
            r_acc  <= n_acc;
            if (i_ctl.save_w) begin
                r_w <= w_sat;
            end
        end
        if (i_load) begin
            r_x <= i_sample;
        end
        // priming a new item takes over from the write-back of the one retiring
        if (i_prime) begin
            r_d1 <= x_sat;
            r_d2 <= x_sat;
            r_x1 <= i_sample;
            r_x2 <= i_sample;
        end else if (i_step) begin
            unique case (i_ctl.wb_op)
                biq_pkg::WB_DF2: begin
                    r_d2 <= r_d1;
                    r_d1 <= r_w;
                end
                biq_pkg::WB_DF1: begin
                    r_d2 <= r_d1;
                    r_d1 <= w_sat;
                    r_x2 <= r_x1;
                    r_x1 <= r_x;
                end
                default: ;
            endcase
        end
    end

endmodule
